// File: rtl/rosc_pkg.sv
// Shared types, constants and register codes for the resize output size calculator.
`timescale 1ns / 1ps

package rosc_pkg;

    // Geometry of one item
    localparam int DIMENSIONS = 2;
    localparam int DIM_W      = 16;
    localparam int TDATA_W    = DIMENSIONS * DIM_W;
    // Rounded scale numerator 2*src*n + d never reaches 2^(2*DIM_W+1)
    localparam int NUM_W      = 2 * DIM_W + 1;
    localparam int DSOR_W     = DIM_W + 1;
    localparam int CNT_W      = $clog2(DIM_W);

    // Queue between classifier and divider
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALING_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 2'd3;

    // Scaling modes
    localparam logic [1:0] MODE_DEFAULT     = 2'd0;
    localparam logic [1:0] MODE_STRETCH     = 2'd1;
    localparam logic [1:0] MODE_NOT_SMALLER = 2'd2;
    localparam logic [1:0] MODE_NOT_LARGER  = 2'd3;

    typedef logic [DIM_W-1:0] dim_t;

    // Exact ratio n/d
    typedef struct packed {
        dim_t n;
        dim_t d;
    } ratio_t;

    typedef struct packed {
        dim_t       target_width;
        dim_t       target_height;
        logic [1:0] scale_mode;
        dim_t       size_limit;
    } cfg_t;

    // One classified item, ready for the divider
    typedef struct packed {
        logic [DIMENSIONS-1:0]            use_div;
        logic [DIMENSIONS-1:0][NUM_W-1:0] num;
        logic [DIMENSIONS-1:0][DIM_W-1:0] direct;
        dim_t                             den;
        logic                             clamp;
        dim_t                             size_limit;
    } item_t;

endpackage

// File: rtl/rosc_front.sv
// Front end: accepts a source size, picks the ratio and builds the divider job.
`timescale 1ns / 1ps

module rosc_front
    import rosc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,     // src_width, src_height
    input  cfg_t               cfg,
    output logic               push,
    output item_t              push_data,
    input  logic               queue_full
);

    localparam logic [2:0] ST_SEL  = 3'd0;
    localparam logic [2:0] ST_LIM0 = 3'd1;
    localparam logic [2:0] ST_LIM1 = 3'd2;
    localparam logic [2:0] ST_EQ0  = 3'd3;
    localparam logic [2:0] ST_EQ1  = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic                  busy_reg, busy_next;
    logic [2:0]            step_reg, step_next;
    dim_t                  src_reg   [DIMENSIONS];
    dim_t                  src_next  [DIMENSIONS];
    ratio_t                scale_reg [DIMENSIONS];
    ratio_t                scale_next[DIMENSIONS];
    logic [DIMENSIONS-1:0] has_reg, has_next;
    logic [DIMENSIONS-1:0] div_reg, div_next;
    ratio_t                fin_reg, fin_next;

    dim_t                  tgt     [DIMENSIONS];
    dim_t                  in_src  [DIMENSIONS];
    ratio_t                in_scale[DIMENSIONS];
    logic [DIMENSIONS-1:0] in_has;
    logic                  s_accept;
    logic                  mode_ext;
    logic                  lim_on;
    ratio_t                cmp_a, cmp_b;
    logic [2*DIM_W-1:0]    cmp_p1, cmp_p2;
    logic                  cmp_less, cmp_eq;
    ratio_t                sel_fin;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign mode_ext = (cfg.scale_mode == MODE_NOT_SMALLER) ||
                      (cfg.scale_mode == MODE_NOT_LARGER);
    assign lim_on   = mode_ext && (cfg.size_limit != '0);
    assign tgt[0]   = cfg.target_width;
    assign tgt[1]   = cfg.target_height;

    // Classify the incoming beat
    always_comb
    begin
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            in_src[i] = s_tdata[i*DIM_W +: DIM_W];
            in_has[i] = (in_src[i] != '0) && (tgt[i] != '0);
            if (in_src[i] != '0)
            begin
                in_scale[i].n = tgt[i];
                in_scale[i].d = in_src[i];
            end
            else
            begin
                in_scale[i].n = DIM_W'(1);
                in_scale[i].d = DIM_W'(1);
            end
        end
    end

    // Shared cross-multiply compare; the push step reuses it for src * fin.n
    always_comb
    begin
        cmp_a = scale_reg[0];
        cmp_b = fin_reg;
        case (step_reg)
            ST_SEL:
            begin
                cmp_a = scale_reg[0];
                cmp_b = scale_reg[1];
            end
            ST_LIM0:
            begin
                cmp_a.n = cfg.size_limit;
                cmp_a.d = src_reg[0];
            end
            ST_LIM1:
            begin
                cmp_a.n = cfg.size_limit;
                cmp_a.d = src_reg[1];
            end
            ST_EQ0:  cmp_a = scale_reg[0];
            ST_EQ1:  cmp_a = scale_reg[1];
            ST_PUSH:
            begin
                cmp_a.n = src_reg[0];
                cmp_a.d = src_reg[1];
                cmp_b.n = fin_reg.n;
                cmp_b.d = fin_reg.n;
            end
            default: cmp_a = scale_reg[0];
        endcase
        cmp_p1   = cmp_a.n * cmp_b.d;
        cmp_p2   = cmp_b.n * cmp_a.d;
        cmp_less = cmp_p1 < cmp_p2;
        cmp_eq   = cmp_p1 == cmp_p2;
    end

    // Start ratio: extreme scale, else first sized dimension's scale
    always_comb
    begin
        if (mode_ext)
        begin
            if (has_reg[0] && has_reg[1])
            begin
                if (cfg.scale_mode == MODE_NOT_SMALLER)
                    sel_fin = cmp_less ? scale_reg[1] : scale_reg[0];
                else
                    sel_fin = (!cmp_less && !cmp_eq) ? scale_reg[1] : scale_reg[0];
            end
            else if (has_reg[0])
                sel_fin = scale_reg[0];
            else if (has_reg[1])
                sel_fin = scale_reg[1];
            else
            begin
                sel_fin.n = '0;
                sel_fin.d = DIM_W'(1);
            end
        end
        else
        begin
            if (has_reg[0])
                sel_fin = scale_reg[0];
            else if (has_reg[1])
                sel_fin = scale_reg[1];
            else
            begin
                sel_fin.n = DIM_W'(1);
                sel_fin.d = DIM_W'(1);
            end
        end
    end

    // Job for the back end
    always_comb
    begin
        push_data.use_div  = div_reg;
        push_data.num[0]   = {cmp_p1, 1'b0} + NUM_W'(fin_reg.d);
        push_data.num[1]   = {cmp_p2, 1'b0} + NUM_W'(fin_reg.d);
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            if (cfg.scale_mode == MODE_STRETCH && !has_reg[i])
                push_data.direct[i] = src_reg[i];
            else
                push_data.direct[i] = tgt[i];
        end
        push_data.den        = fin_reg.d;
        push_data.clamp      = !mode_ext && (cfg.size_limit != '0);
        push_data.size_limit = cfg.size_limit;
    end

    // Step sequencer
    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        src_next   = src_reg;
        scale_next = scale_reg;
        has_next   = has_reg;
        div_next   = div_reg;
        fin_next   = fin_reg;
        push       = 1'b0;
        if (s_accept)
        begin
            busy_next  = 1'b1;
            step_next  = ST_SEL;
            src_next   = in_src;
            scale_next = in_scale;
            has_next   = in_has;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                ST_SEL:
                begin
                    fin_next  = sel_fin;
                    step_next = ST_LIM0;
                end
                ST_LIM0:
                begin
                    if (lim_on && src_reg[0] != '0 && cmp_less)
                        fin_next = cmp_a;
                    step_next = ST_LIM1;
                end
                ST_LIM1:
                begin
                    if (lim_on && src_reg[1] != '0 && cmp_less)
                        fin_next = cmp_a;
                    step_next = ST_EQ0;
                end
                ST_EQ0:
                begin
                    div_next[0] = mode_ext ? (!has_reg[0] || !cmp_eq)
                                           : (cfg.scale_mode == MODE_DEFAULT && !has_reg[0]);
                    step_next   = ST_EQ1;
                end
                ST_EQ1:
                begin
                    div_next[1] = mode_ext ? (!has_reg[1] || !cmp_eq)
                                           : (cfg.scale_mode == MODE_DEFAULT && !has_reg[1]);
                    step_next   = ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (!queue_full)
                    begin
                        push      = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_SEL;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        scale_reg <= scale_next;
        has_reg   <= has_next;
        div_reg   <= div_next;
        fin_reg   <= fin_next;
    end

    // The chosen ratio never has a zero denominator once selected
    a_fin_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg != ST_SEL |-> fin_reg.d != '0)
        else $error("ratio denominator is zero");

endmodule

// File: rtl/rosc_fifo.sv
// Short job queue between the front end and the divider.
`timescale 1ns / 1ps

module rosc_fifo
    import rosc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  empty
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue write while full");

endmodule

// File: rtl/rosc_back.sv
// Back end: rounded scaling by a radix-2 divider per dimension, clamp, output register.
`timescale 1ns / 1ps

module rosc_back
    import rosc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  item_t              queue_data,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata      // out_width, out_height
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DSOR_W-1:0]     dsor_reg, dsor_next;
    logic [DSOR_W-1:0]     rem_reg [DIMENSIONS];
    logic [DSOR_W-1:0]     rem_next[DIMENSIONS];
    dim_t                  sh_reg  [DIMENSIONS];
    dim_t                  sh_next [DIMENSIONS];
    dim_t                  q_reg   [DIMENSIONS];
    dim_t                  q_next  [DIMENSIONS];
    dim_t                  dir_reg [DIMENSIONS];
    dim_t                  dir_next[DIMENSIONS];
    logic [DIMENSIONS-1:0] ovf_reg, ovf_next;
    logic [DIMENSIONS-1:0] use_div_reg, use_div_next;
    logic                  clamp_reg, clamp_next;
    dim_t                  max_reg, max_next;
    logic                  out_valid_reg, out_valid_next;
    dim_t                  out_reg [DIMENSIONS];
    dim_t                  out_next[DIMENSIONS];

    logic                  out_free;
    logic                  load;
    logic [DSOR_W-1:0]     new_dsor;
    logic [DSOR_W-1:0]     hi     [DIMENSIONS];
    logic [DSOR_W:0]       trial  [DIMENSIONS];
    logic [DSOR_W:0]       diff   [DIMENSIONS];
    logic                  ge     [DIMENSIONS];
    dim_t                  res    [DIMENSIONS];

    assign out_free = !out_valid_reg || m_tready;
    assign load     = !queue_empty &&
                      (state_reg == ST_IDLE || (state_reg == ST_DONE && out_free));
    assign pop      = load;
    assign new_dsor = {queue_data.den, 1'b0};
    assign m_tvalid = out_valid_reg;

    // One quotient bit per lane per cycle, plus the final select and clamp
    always_comb
    begin
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            hi[i]    = queue_data.num[i][NUM_W-1:DIM_W];
            trial[i] = {rem_reg[i], sh_reg[i][DIM_W-1]};
            diff[i]  = trial[i] - {1'b0, dsor_reg};
            ge[i]    = trial[i] >= {1'b0, dsor_reg};
            if (use_div_reg[i])
                res[i] = ovf_reg[i] ? {DIM_W{1'b1}} : q_reg[i];
            else
                res[i] = dir_reg[i];
            if (clamp_reg && res[i] > max_reg)
                res[i] = max_reg;
        end
    end

    // Divider sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dsor_next      = dsor_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        q_next         = q_reg;
        dir_next       = dir_reg;
        ovf_next       = ovf_reg;
        use_div_next   = use_div_reg;
        clamp_next     = clamp_reg;
        max_next       = max_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: ;
            ST_RUN:
            begin
                for (int i = 0; i < DIMENSIONS; i++)
                begin
                    rem_next[i] = ge[i] ? diff[i][DSOR_W-1:0] : trial[i][DSOR_W-1:0];
                    q_next[i]   = {q_reg[i][DIM_W-2:0], ge[i]};
                    sh_next[i]  = {sh_reg[i][DIM_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (load)
        begin
            state_next   = ST_RUN;
            cnt_next     = CNT_W'(DIM_W - 1);
            dsor_next    = new_dsor;
            use_div_next = queue_data.use_div;
            clamp_next   = queue_data.clamp;
            max_next     = queue_data.size_limit;
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                ovf_next[i] = hi[i] >= new_dsor;
                rem_next[i] = hi[i];
                sh_next[i]  = queue_data.num[i][DIM_W-1:0];
                q_next[i]   = '0;
                dir_next[i] = queue_data.direct[i];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dsor_reg    <= dsor_next;
        rem_reg     <= rem_next;
        sh_reg      <= sh_next;
        q_reg       <= q_next;
        dir_reg     <= dir_next;
        ovf_reg     <= ovf_next;
        use_div_reg <= use_div_next;
        clamp_reg   <= clamp_next;
        max_reg     <= max_next;
        out_reg     <= out_next;
    end

    // Output beat: width in the low half
    always_comb
    begin
        for (int i = 0; i < DIMENSIONS; i++)
            m_tdata[i*DIM_W +: DIM_W] = out_reg[i];
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE || state_reg == ST_DONE)
        else $error("divider loaded while busy");

    a_rem_below_dsor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && !ovf_reg[0] && use_div_reg[0] |-> rem_reg[0] < dsor_reg)
        else $error("partial remainder out of range");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result shown without finished division");

endmodule

// File: rtl/resize_output_size_calc.sv
// Top level of the resize output size calculator: configuration registers and hookup.
//
// Use: write target_width (0), target_height (1), scale_mode (2) and size_limit (3)
// on the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while no item is in
// flight; cfg_ready is always high. Then stream source crop sizes on s_tdata
// (src_width in bits 15:0, src_height in 31:16); each beat gives one output beat on
// m_tdata (out_width in 15:0, out_height in 31:16), in order.
// The front end takes no new beat until it has pushed the last one; sustained throughput is
// set by the 16-step restoring divider in the back end (one quotient bit per cycle, both
// dimensions in parallel), which takes a new item only once the last one is done.
// A two-entry queue sits between front and back.
// Reset clears all configuration to zero, empties the queue and drops m_tvalid.
// If the receiver stalls, the result waits in the output register, the divider
// finishes the next item and holds it, the queue fills, and s_tready stays low.
`timescale 1ns / 1ps

module resize_output_size_calc
    import rosc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,     // src_width, src_height
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,     // out_width, out_height
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  push, queue_full, pop, queue_empty;
    item_t push_data, queue_data;

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET_WIDTH:  cfg_next.target_width  = cfg_data;
                REG_TARGET_HEIGHT: cfg_next.target_height = cfg_data;
                REG_SCALING_MODE:  cfg_next.scale_mode    = cfg_data[1:0];
                REG_MAX_SIZE:      cfg_next.size_limit    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    rosc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    rosc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (queue_data),
        .empty     (queue_empty)
    );

    rosc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (queue_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
